// ===== sv/prc_pkg.sv =====
package prc_pkg;

  // Action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_COMMAND = 2'd0,
    ACT_ESTOP   = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_STATUS  = 2'd3
  } action_t;

  // Refusal codes of a result transaction
  typedef enum logic [1:0] {
    REFUSE_NONE       = 2'd0,
    REFUSE_EMERGENCY  = 2'd1,
    REFUSE_PROTECTION = 2'd2
  } refuse_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAX_RUNTIME = 3'd0;
  localparam logic [2:0] CFG_COOLDOWN    = 3'd1;
  localparam logic [2:0] CFG_WINDOW      = 3'd2;
  localparam logic [2:0] CFG_MAX_STARTS  = 3'd3;
  localparam logic [2:0] CFG_INVERT      = 3'd4;

  // Configuration reset values
  localparam logic [31:0] RST_MAX_RUNTIME = 32'd3600000;
  localparam logic [31:0] RST_COOLDOWN    = 32'd0;
  localparam logic [31:0] RST_WINDOW      = 32'd3600000;
  localparam logic [15:0] RST_MAX_STARTS  = 16'hFFFF;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_LIM,
    ST_CHK_EL,
    ST_CHK_CD,
    ST_WIN,
    ST_SCAN,
    ST_CNT,
    ST_APPLY,
    ST_STOP_EL,
    ST_STOP_ADD,
    ST_TOT_EL,
    ST_TOT_ADD
  } state_t;

endpackage

// ===== sv/pump_runtime_protection_controller.sv =====
// Channel | Direction | Handshake           | Payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_stall   | in_action, in_desired_on, in_now_ms
// out     | out       | out_valid/out_stall | accepted, refuse_code, pin_level, pump_running,
//         |           |                     | emergency_latched, runtime_total_ms
//
// Steps: a command asking for on with no emergency latched runs the limit, cooldown,
//   window and history-scan checks before the decision, or leaves at the cooldown check
//   when the cooldown refuses it; others skip to the decision. One shared 32-bit
//   adder/comparator does every less-than and 32-bit sum; the scan reads one entry per cycle.
// in_stall is high from acceptance until the result is loaded into the output register.
// Reset (rst_n, synchronous) gives pump off, no emergency, empty history, reset config.
// A stalled result holds in the output register; the sequencer waits at its last step.
module pump_runtime_protection_controller #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic        in_desired_on,
  input  logic [31:0] in_now_ms,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [1:0]  out_refuse_code,
  output logic        out_pin_level,
  output logic        out_pump_running,
  output logic        out_emergency_latched,
  output logic [31:0] out_runtime_total_ms
);
  import prc_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

  // configuration registers
  logic [31:0] max_runtime_r, cooldown_r, window_r;
  logic [15:0] max_starts_r;
  logic        invert_r;

  // sequencer and transaction registers
  state_t      state_r, state_nxt;
  action_t     act_r, act_nxt;
  logic        want_r, want_nxt;
  logic [31:0] now_r, now_nxt;
  logic        lim_r, lim_nxt;
  logic        blk_r, blk_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [31:0] wb_r, wb_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic        ok_r, ok_nxt;
  refuse_t     refuse_r, refuse_nxt;

  // pump state
  logic        running_r, running_nxt;
  logic        emerg_r, emerg_nxt;
  logic [31:0] run_start_r, run_start_nxt;
  logic [31:0] last_stop_r, last_stop_nxt;
  logic [31:0] accum_r, accum_nxt;

  // start history: circular buffer with per-entry valid bits
  logic [31:0]              hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_vld_r;
  logic [IDX_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic                     hist_we;
  logic [IDX_W-1:0]         rd_addr;
  logic [31:0]              rd_q_r;
  logic                     rdv_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_acc_r, out_acc_nxt;
  refuse_t     out_ref_r, out_ref_nxt;
  logic        out_run_r, out_run_nxt;
  logic        out_emerg_r, out_emerg_nxt;
  logic [31:0] out_tot_r, out_tot_nxt;

  // shared adder
  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_lt;

  logic in_take, out_free, sw_req, sw_on;

  prc_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_runtime_r <= RST_MAX_RUNTIME;
      cooldown_r    <= RST_COOLDOWN;
      window_r      <= RST_WINDOW;
      max_starts_r  <= RST_MAX_STARTS;
      invert_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RUNTIME: max_runtime_r <= cfg_data;
        CFG_COOLDOWN:    cooldown_r    <= cfg_data;
        CFG_WINDOW:      window_r      <= cfg_data;
        CFG_MAX_STARTS:  max_starts_r  <= cfg_data[15:0];
        CFG_INVERT:      invert_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // history memory: write on start, registered read for the scan
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wr_ptr_r] <= now_r;
    end
    rd_q_r <= hist_mem[rd_addr];
    rdv_r  <= hist_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (hist_we) begin
      hist_vld_r[wr_ptr_r] <= 1'b1;
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= 1'b0;
      emerg_r     <= 1'b0;
      run_start_r <= '0;
      last_stop_r <= '0;
      accum_r     <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      emerg_r     <= emerg_nxt;
      run_start_r <= run_start_nxt;
      last_stop_r <= last_stop_nxt;
      accum_r     <= accum_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    want_r      <= want_nxt;
    now_r       <= now_nxt;
    lim_r       <= lim_nxt;
    blk_r       <= blk_nxt;
    tmp_r       <= tmp_nxt;
    wb_r        <= wb_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    ok_r        <= ok_nxt;
    refuse_r    <= refuse_nxt;
    out_acc_r   <= out_acc_nxt;
    out_ref_r   <= out_ref_nxt;
    out_run_r   <= out_run_nxt;
    out_emerg_r <= out_emerg_nxt;
    out_tot_r   <= out_tot_nxt;
  end

  // next state, adder operand selection and state updates
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    want_nxt      = want_r;
    now_nxt       = now_r;
    lim_nxt       = lim_r;
    blk_nxt       = blk_r;
    tmp_nxt       = tmp_r;
    wb_nxt        = wb_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    refuse_nxt    = refuse_r;
    running_nxt   = running_r;
    emerg_nxt     = emerg_r;
    run_start_nxt = run_start_r;
    last_stop_nxt = last_stop_r;
    accum_nxt     = accum_r;
    wr_ptr_nxt    = wr_ptr_r;
    hist_we       = 1'b0;
    rd_addr       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_ref_nxt   = out_ref_r;
    out_run_nxt   = out_run_r;
    out_emerg_nxt = out_emerg_r;
    out_tot_nxt   = out_tot_r;
    alu_op        = ALU_SUB;
    alu_a         = now_r;
    alu_b         = run_start_r;
    sw_req        = 1'b0;
    sw_on         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          act_nxt    = action_t'(in_action);
          want_nxt   = in_desired_on;
          now_nxt    = in_now_ms;
          blk_nxt    = 1'b0;
          ok_nxt     = 1'b1;
          refuse_nxt = REFUSE_NONE;
          if (action_t'(in_action) == ACT_COMMAND && !emerg_r && in_desired_on) begin
            state_nxt = ST_CHK_LIM;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      // runtime limit reached and a stop on record
      ST_CHK_LIM: begin
        alu_a     = accum_r;
        alu_b     = max_runtime_r;
        lim_nxt   = !alu_lt && (last_stop_r != '0);
        state_nxt = ST_CHK_EL;
      end
      ST_CHK_EL: begin
        alu_a     = now_r;
        alu_b     = last_stop_r;
        tmp_nxt   = alu_res;
        state_nxt = ST_CHK_CD;
      end
      // cooldown not yet passed while the runtime limit holds
      ST_CHK_CD: begin
        alu_a = tmp_r;
        alu_b = cooldown_r;
        if (lim_r && alu_lt) begin
          blk_nxt   = 1'b1;
          state_nxt = ST_APPLY;
        end else begin
          state_nxt = ST_WIN;
        end
      end
      // window start; first history read goes out
      ST_WIN: begin
        alu_a     = now_r;
        alu_b     = window_r;
        wb_nxt    = alu_res;
        cnt_nxt   = '0;
        idx_nxt   = '0;
        rd_addr   = '0;
        state_nxt = ST_SCAN;
      end
      // one history entry per cycle
      ST_SCAN: begin
        alu_a   = rd_q_r;
        alu_b   = wb_r;
        rd_addr = idx_r + IDX_W'(1);
        if (rdv_r && rd_q_r != '0 && !alu_lt) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_CNT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_CNT: begin
        alu_a     = 32'(cnt_r);
        alu_b     = 32'(max_starts_r);
        blk_nxt   = !alu_lt;
        state_nxt = ST_APPLY;
      end
      // decision and pump state change
      ST_APPLY: begin
        case (act_r)
          ACT_COMMAND: begin
            if (emerg_r) begin
              ok_nxt     = 1'b0;
              refuse_nxt = REFUSE_EMERGENCY;
            end else if (want_r && blk_r) begin
              ok_nxt     = 1'b0;
              refuse_nxt = REFUSE_PROTECTION;
            end else begin
              sw_req = 1'b1;
              sw_on  = want_r;
            end
          end
          ACT_ESTOP: begin
            emerg_nxt = 1'b1;
            sw_req    = 1'b1;
            sw_on     = 1'b0;
          end
          ACT_CLEAR: begin
            emerg_nxt = 1'b0;
          end
          default: ;
        endcase
        state_nxt = ST_TOT_EL;
        if (sw_req && sw_on != running_r) begin
          running_nxt = sw_on;
          if (sw_on) begin
            run_start_nxt = now_r;
            hist_we       = 1'b1;
            wr_ptr_nxt    = (wr_ptr_r == IDX_LAST) ? '0 : wr_ptr_r + IDX_W'(1);
          end else if (run_start_r != '0) begin
            state_nxt = ST_STOP_EL;
          end
        end
      end
      // close out a finished run
      ST_STOP_EL: begin
        tmp_nxt   = alu_res;
        state_nxt = ST_STOP_ADD;
      end
      ST_STOP_ADD: begin
        alu_op        = ALU_ADD;
        alu_a         = accum_r;
        alu_b         = tmp_r;
        accum_nxt     = alu_res;
        run_start_nxt = '0;
        last_stop_nxt = now_r;
        state_nxt     = ST_TOT_EL;
      end
      // total runtime including the current run
      ST_TOT_EL: begin
        tmp_nxt   = alu_res;
        state_nxt = ST_TOT_ADD;
      end
      ST_TOT_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = accum_r;
        alu_b  = tmp_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = ok_r;
          out_ref_nxt   = refuse_r;
          out_run_nxt   = running_r;
          out_emerg_nxt = emerg_r;
          out_tot_nxt   = (running_r && run_start_r != '0) ? alu_res : accum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = out_acc_r;
  assign out_refuse_code       = out_ref_r;
  assign out_pin_level         = out_run_r ^ invert_r;
  assign out_pump_running      = out_run_r;
  assign out_emergency_latched = out_emerg_r;
  assign out_runtime_total_ms  = out_tot_r;

`ifndef NO_ASSERTIONS
  // emergency latch and a running pump never coexist
  a_no_run_in_emerg: assert property (@(posedge clk) disable iff (!rst_n)
    !(running_r && emerg_r))
    else $error("pump running while emergency latched");

  // a result is accepted exactly when it carries no refusal
  a_refuse_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_refuse_code == REFUSE_NONE)))
    else $error("accepted flag disagrees with refuse code");

  // an accepted transaction blocks the input until its result is formed
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after acceptance");

  // history write pointer stays inside the buffer
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= IDX_LAST)
    else $error("history pointer out of range");
`endif

endmodule

// ===== sv/prc_alu.sv =====
module prc_alu (
  input  prc_pkg::alu_op_t op,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic [31:0]      res,
  output logic             lt
);
  import prc_pkg::*;

  logic [32:0] sum;
  logic [31:0] b_sel;

  // One 32-bit adder; subtraction by inverted operand and carry in
  always_comb begin
    b_sel = (op == ALU_SUB) ? ~b : b;
    sum   = {1'b0, a} + {1'b0, b_sel} + {32'd0, (op == ALU_SUB)};
    res   = sum[31:0];
    // unsigned a < b when subtraction produces no carry out
    lt    = (op == ALU_SUB) && !sum[32];
  end

endmodule
